// File: src/wsfi_pkg.sv
// Shared types, constants and helpers for the wheel speed fault injector.
package wsfi_pkg;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_MIN_SPEED         = 3'd0;
   localparam logic [2:0] REG_NOISE_GAIN        = 3'd1;
   localparam logic [2:0] REG_OUTLIER_THRESHOLD = 3'd2;
   localparam logic [2:0] REG_OUTLIER_SCALE     = 3'd3;
   localparam logic [2:0] REG_DROPOUT_THRESHOLD = 3'd4;
   localparam logic [2:0] REG_QUANT_BITS        = 3'd5;

   // rad/s to rpm, 1/1024 rad/s in, 1/16 rpm out, Q24
   localparam logic [21:0] RPM_K_Q24   = 22'd2503291;
   localparam int          QUANT_LIMIT = 64000;
   localparam int          QUANT_SPAN  = 2 * QUANT_LIMIT;

   // level index: t / 125 as (t * ceil(2^45 / 125)) >> 45, exact for t below 125 * 2^31
   localparam logic [38:0] IDX_RECIP   = 39'd281474976711;
   localparam int          IDX_SHIFT   = 45;
   // level value divider: quotient fits in 17 bits
   localparam int          LVL_STEPS   = 17;
   localparam logic [17:0] LVL_SCALE   = 18'(2 * QUANT_SPAN);

   typedef struct packed {
      logic signed [20:0] wheel_speed;
      logic signed [15:0] noise_sample;
      logic [15:0]        outlier_draw;
      logic [15:0]        sign_draw;
      logic [15:0]        dropout_draw;
   } req_type;

   typedef struct packed {
      logic signed [19:0] rpm_out;
      logic               dropped;
   } rsp_type;

   typedef struct packed {
      logic [19:0] min_speed;
      logic [15:0] noise_gain;
      logic [16:0] outlier_threshold;
      logic [15:0] outlier_scale;
      logic [16:0] dropout_threshold;
      logic [4:0]  quant_bits;
   } cfg_type;

   // Sideband that rides along the quantizer pipeline
   typedef struct packed {
      logic               qen;
      logic               dropped;
      logic signed [19:0] satv;
   } side_type;

   // number of quantizer levels minus one
   function automatic logic [30:0] lm1_of(input logic [4:0] bits);
      logic [31:0] full;
      full = (32'd1 << bits) - 32'd1;
      return full[30:0];
   endfunction

endpackage

// File: src/wsfi_front.sv
// Error chain and rpm conversion: seven pipeline stages up to the quantizer prescale.
module wsfi_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  wsfi_pkg::cfg_type cfg,
   input  logic              in_valid,
   input  wsfi_pkg::req_type in_data,
   output logic              out_valid,
   output logic [37:0]       out_t,
   output wsfi_pkg::side_type out_side
);
   import wsfi_pkg::*;

   logic [6:0] v_ff, v_in;

   // stage A: cutoff, noise product, draw compares
   logic [20:0]        mag0;
   logic signed [20:0] a_m_ff, a_m_in;
   logic signed [32:0] a_p_ff, a_p_in;
   logic a_out_ff, a_out_in, a_neg_ff, a_neg_in, a_drop_ff, a_drop_in;

   always_comb begin
      mag0 = in_data.wheel_speed[20] ? (~in_data.wheel_speed + 21'd1) : in_data.wheel_speed;
      a_m_in = (mag0 < {1'b0, cfg.min_speed}) ? '0 : in_data.wheel_speed;
      a_p_in = $signed({1'b0, cfg.noise_gain}) * in_data.noise_sample;
      a_out_in = {1'b0, in_data.outlier_draw} < cfg.outlier_threshold;
      a_neg_in = ~in_data.sign_draw[15];
      a_drop_in = {1'b0, in_data.dropout_draw} < cfg.dropout_threshold;
   end

   // stage B: round noise, add
   logic signed [32:0] psum;
   logic signed [21:0] b_m_ff, b_m_in;
   logic b_out_ff, b_neg_ff, b_drop_ff;

   always_comb begin
      psum = a_p_ff + 33'sd2048;
      b_m_in = {a_m_ff[20], a_m_ff} + {psum[32], psum[32:12]};
   end

   // stage C: outlier product
   logic [21:0]        mag1;
   logic [37:0]        c_prod_ff, c_prod_in;
   logic signed [21:0] c_m_ff;
   logic c_out_ff, c_neg_ff, c_drop_ff;

   always_comb begin
      mag1 = b_m_ff[21] ? (~b_m_ff + 22'd1) : b_m_ff;
      c_prod_in = cfg.outlier_scale * mag1;
   end

   // stage D: apply outlier and dropout
   logic [37:0]        dsum;
   logic signed [31:0] mext, dext;
   logic signed [31:0] d_m_ff, d_m_in;
   logic d_drop_ff;

   always_comb begin
      dsum = c_prod_ff + 38'd128;
      mext = {{10{c_m_ff[21]}}, c_m_ff};
      dext = {2'b00, dsum[37:8]};
      d_m_in = mext;
      if (c_out_ff) begin
         d_m_in = c_neg_ff ? (mext - dext) : (mext + dext);
      end
      if (c_drop_ff) begin
         d_m_in = '0;
      end
   end

   // stage E: rpm product
   logic signed [54:0] e_prod_ff, e_prod_in;
   logic e_drop_ff;

   assign e_prod_in = d_m_ff * $signed({1'b0, RPM_K_Q24});

   // stage F: round to 1/16 rpm
   logic signed [54:0] esum;
   logic signed [30:0] f_rpm_ff, f_rpm_in;
   logic f_drop_ff;

   always_comb begin
      esum = e_prod_ff + 55'sd8388608;
      f_rpm_in = esum[54:24];
   end

   // stage G: saturate, clamp and prescale for the level index
   logic signed [17:0] cq, xs;
   logic [5:0]         sh;
   logic [48:0]        n1;
   logic [37:0]        g_t_ff, g_t_in;
   side_type           g_side_ff, g_side_in;

   always_comb begin
      priority if (f_rpm_ff > 31'sd64000) begin
         cq = 18'sd64000;
      end else if (f_rpm_ff < -31'sd64000) begin
         cq = -18'sd64000;
      end else begin
         cq = f_rpm_ff[17:0];
      end
      xs = cq + 18'sd64000;
      sh = {1'b0, cfg.quant_bits} + 6'd1;
      n1 = ({32'd0, xs[16:0]} << sh) - ({32'd0, xs[16:0]} << 1) + 49'(QUANT_SPAN);
      g_t_in = n1[48:11];
      priority if (f_rpm_ff > 31'sd524287) begin
         g_side_in.satv = 20'sh7FFFF;
      end else if (f_rpm_ff < -31'sd524288) begin
         g_side_in.satv = -20'sd524288;
      end else begin
         g_side_in.satv = f_rpm_ff[19:0];
      end
      g_side_in.qen = cfg.quant_bits != '0;
      g_side_in.dropped = f_drop_ff;
   end

   // valid chain
   assign v_in = {v_ff[5:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         a_m_ff <= a_m_in;
         a_p_ff <= a_p_in;
         a_out_ff <= a_out_in;
         a_neg_ff <= a_neg_in;
         a_drop_ff <= a_drop_in;
         b_m_ff <= b_m_in;
         b_out_ff <= a_out_ff;
         b_neg_ff <= a_neg_ff;
         b_drop_ff <= a_drop_ff;
         c_prod_ff <= c_prod_in;
         c_m_ff <= b_m_ff;
         c_out_ff <= b_out_ff;
         c_neg_ff <= b_neg_ff;
         c_drop_ff <= b_drop_ff;
         d_m_ff <= d_m_in;
         d_drop_ff <= c_drop_ff;
         e_prod_ff <= e_prod_in;
         e_drop_ff <= d_drop_ff;
         f_rpm_ff <= f_rpm_in;
         f_drop_ff <= e_drop_ff;
         g_t_ff <= g_t_in;
         g_side_ff <= g_side_in;
      end
   end

   assign out_valid = v_ff[6];
   assign out_t = g_t_ff;
   assign out_side = g_side_ff;

endmodule

// File: src/wsfi_idx_div.sv
// Level index: divide by 125 through a reciprocal multiply, three stages.
module wsfi_idx_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [37:0]        in_t,
   input  wsfi_pkg::side_type in_side,
   output logic               out_valid,
   output logic [30:0]        out_idx,
   output wsfi_pkg::side_type out_side
);
   import wsfi_pkg::*;

   // stage 1: four partial products of t times the reciprocal
   logic [18:0] th, tl, mh;
   logic [19:0] ml;
   logic [37:0] hh_ff, hh_in, lh_ff, lh_in;
   logic [38:0] hl_ff, hl_in, ll_ff, ll_in;
   logic        v1_ff;
   side_type    s1_ff;

   always_comb begin
      th = in_t[37:19];
      tl = in_t[18:0];
      mh = IDX_RECIP[38:20];
      ml = IDX_RECIP[19:0];
      hh_in = th * mh;
      hl_in = th * ml;
      lh_in = tl * mh;
      ll_in = tl * ml;
   end

   // stage 2: merge the cross terms
   logic [39:0] mid_ff, mid_in;
   logic [37:0] hh2_ff;
   logic [38:0] ll2_ff;
   logic        v2_ff;
   side_type    s2_ff;

   assign mid_in = {1'b0, hl_ff} + {1'b0, lh_ff, 1'b0};

   // stage 3: full product, keep the quotient bits
   logic [76:0] total;
   logic [30:0] q_ff, q_in;
   logic        v3_ff;
   side_type    s3_ff;

   always_comb begin
      total = {hh2_ff, 39'd0} + {18'd0, mid_ff, 19'd0} + {38'd0, ll2_ff};
      q_in = total[IDX_SHIFT+30:IDX_SHIFT];
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff <= hh_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
         ll_ff <= ll_in;
         s1_ff <= in_side;
         mid_ff <= mid_in;
         hh2_ff <= hh_ff;
         ll2_ff <= ll_ff;
         s2_ff <= s1_ff;
         q_ff <= q_in;
         s3_ff <= s2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_idx = q_ff;
   assign out_side = s3_ff;

endmodule

// File: src/wsfi_lvl_div.sv
// Level value: index times span, then restoring divide by twice (level count - 1).
module wsfi_lvl_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  wsfi_pkg::cfg_type  cfg,
   input  logic               in_valid,
   input  logic [30:0]        in_idx,
   input  wsfi_pkg::side_type in_side,
   output logic               out_valid,
   output logic [16:0]        out_q,
   output wsfi_pkg::side_type out_side
);
   import wsfi_pkg::*;

   logic [30:0] lm1;
   logic [31:0] dvs;

   assign lm1 = lm1_of(cfg.quant_bits);
   assign dvs = {lm1, 1'b0};

   // numerator stage
   logic [48:0] n_ff, n_in;
   logic        nv_ff;
   side_type    ns_ff;

   assign n_in = (in_idx * LVL_SCALE) + {18'd0, lm1};

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= 1'b0;
      end else if (en) begin
         nv_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff <= n_in;
         ns_ff <= in_side;
      end
   end

   logic [31:0] r_ff [LVL_STEPS];
   logic [16:0] w_ff [LVL_STEPS];
   logic        v_ff [LVL_STEPS];
   side_type    s_ff [LVL_STEPS];

   for (genvar k = 0; k < LVL_STEPS; k++) begin : g_step
      logic [31:0] r_pre, r_in;
      logic [16:0] w_pre, w_in;
      logic        v_pre;
      side_type    s_pre;
      logic [32:0] rr, rd;
      logic        ge;

      if (k == 0) begin : g_first
         // quotient fits in 17 bits, so the upper part is below the divisor
         assign r_pre = n_ff[48:17];
         assign w_pre = n_ff[16:0];
         assign v_pre = nv_ff;
         assign s_pre = ns_ff;
      end else begin : g_next
         assign r_pre = r_ff[k-1];
         assign w_pre = w_ff[k-1];
         assign v_pre = v_ff[k-1];
         assign s_pre = s_ff[k-1];
      end

      always_comb begin
         rr = {r_pre, w_pre[16]};
         ge = rr >= {1'b0, dvs};
         rd = rr - {1'b0, dvs};
         r_in = ge ? rd[31:0] : rr[31:0];
         w_in = {w_pre[15:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_pre;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k] <= r_in;
            w_ff[k] <= w_in;
            s_ff[k] <= s_pre;
         end
      end
   end

   assign out_valid = v_ff[LVL_STEPS-1];
   assign out_q = w_ff[LVL_STEPS-1];
   assign out_side = s_ff[LVL_STEPS-1];

endmodule

// File: src/wheel_speed_fault_injector.sv
// Top level: register file, pipeline stall control and result register.
//
//   channel   ports                          beat moves on
//   req       req_valid req_stall req_data   valid high, stall low
//   rsp       rsp_valid rsp_stall rsp_data   valid high, stall low
//   csr       psel penable pwrite paddr ...  psel, penable, pwrite high (access)
//
// One beat enters per cycle while no stalled result holds the pipeline. Stages:
// 7 chain, 3 index divider, 18 level divider, then the result register.
// The unrolled level divider sets the depth; one beat per cycle when not stalled.
// Reset clears the valid bits and the configuration registers; payload is not reset.
// A stalled result freezes the whole pipeline; req_stall follows it.
module wheel_speed_fault_injector (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  wsfi_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output wsfi_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import wsfi_pkg::*;

   // configuration registers
   cfg_type    cfg_ff;
   logic [2:0] ridx;
   logic       wr;

   assign pready = 1'b1;
   assign ridx = paddr[4:2];
   assign wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr) begin
         unique case (ridx)
            REG_MIN_SPEED:         cfg_ff.min_speed <= pwdata[19:0];
            REG_NOISE_GAIN:        cfg_ff.noise_gain <= pwdata[15:0];
            REG_OUTLIER_THRESHOLD: cfg_ff.outlier_threshold <= pwdata[16:0];
            REG_OUTLIER_SCALE:     cfg_ff.outlier_scale <= pwdata[15:0];
            REG_DROPOUT_THRESHOLD: cfg_ff.dropout_threshold <= pwdata[16:0];
            REG_QUANT_BITS:        cfg_ff.quant_bits <= pwdata[4:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (ridx)
         REG_MIN_SPEED:         prdata = {12'd0, cfg_ff.min_speed};
         REG_NOISE_GAIN:        prdata = {16'd0, cfg_ff.noise_gain};
         REG_OUTLIER_THRESHOLD: prdata = {15'd0, cfg_ff.outlier_threshold};
         REG_OUTLIER_SCALE:     prdata = {16'd0, cfg_ff.outlier_scale};
         REG_DROPOUT_THRESHOLD: prdata = {15'd0, cfg_ff.dropout_threshold};
         REG_QUANT_BITS:        prdata = {27'd0, cfg_ff.quant_bits};
         default:               prdata = '0;
      endcase
   end

   // global advance: hold everything while a result waits
   logic en;
   logic rsp_valid_ff;

   assign en = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = ~en;

   logic        fv;
   logic [37:0] ft;
   side_type    fs;

   wsfi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (fv),
      .out_t     (ft),
      .out_side  (fs)
   );

   logic        iv;
   logic [30:0] idx;
   side_type    is;

   wsfi_idx_div u_idx (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fv),
      .in_t      (ft),
      .in_side   (fs),
      .out_valid (iv),
      .out_idx   (idx),
      .out_side  (is)
   );

   logic        lv;
   logic [16:0] q;
   side_type    ls;

   wsfi_lvl_div u_lvl (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .in_valid  (iv),
      .in_idx    (idx),
      .in_side   (is),
      .out_valid (lv),
      .out_q     (q),
      .out_side  (ls)
   );

   // result register
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.dropped = ls.dropped;
      rsp_in.rpm_out = ls.qen ? ($signed({3'b000, q}) - 20'sd64000) : ls.satv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= lv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
